// ----- rtl/msscan_pkg.sv -----
`timescale 1ns / 1ps
package msscan_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int PATTERN_BYTES   = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int LEN_CFG_W       = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [63:0] byte_address;
        logic        segment_start;
        logic        search_start;
        logic        last_byte;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [63:0] match_address;
    } t_out;

    typedef struct packed {
        logic [63:0]          pattern_bytes_low;
        logic [63:0]          pattern_bytes_high;
        logic [15:0]          care_mask;
        logic [LEN_CFG_W-1:0] pattern_length;
    } t_cfg;

    // One queued result: the address is the byte that completed the match.
    typedef struct packed {
        logic        found;
        logic [63:0] end_address;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/msscan_front.sv -----
`timescale 1ns / 1ps
module msscan_front #(
    parameter int PATTERN_MAX = msscan_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  msscan_pkg::t_in   i_data,
    output logic              o_stall,
    input  msscan_pkg::t_cfg  i_cfg,
    input  logic [LEN_W-1:0]  i_eff_len,
    input  msscan_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output msscan_pkg::t_qent o_entry
);
    import msscan_pkg::*;

    logic [7:0]       r_window [PATTERN_MAX];
    logic [7:0]       n_window [PATTERN_MAX];
    logic [LEN_W-1:0] r_fill, n_fill;
    logic             r_seen, n_seen;
    logic             accept;
    logic             seen_base;
    logic             all_ok;
    logic             match;
    logic [7:0]       pat [PATTERN_BYTES];
    logic [PATTERN_MAX-1:0] pos_ok;

    assign accept  = i_valid && !i_q_stat.full;
    assign o_stall = i_q_stat.full;

    always_comb begin
        for (int b = 0; b < PATTERN_BYTES; b++) begin
            if (b < 8) begin
                pat[b] = i_cfg.pattern_bytes_low[8*b +: 8];
            end else begin
                pat[b] = i_cfg.pattern_bytes_high[8*(b-8) +: 8];
            end
        end
    end

    // Shift in the new byte; a segment start drops the old window.
    always_comb begin
        n_window[0] = i_data.byte_value;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_window[k] = i_data.segment_start ? 8'd0 : r_window[k-1];
        end
        if (i_data.segment_start) begin
            n_fill = LEN_W'(1);
        end else if (int'(r_fill) < PATTERN_MAX) begin
            n_fill = r_fill + LEN_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    // Window slot k holds the byte that pairs with pattern byte len-1-k.
    always_comb begin
        int j;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            j = int'(i_eff_len) - 1 - k;
            pos_ok[k] = 1'b1;
            if (k < int'(i_eff_len) && j < PATTERN_BYTES) begin
                if (i_cfg.care_mask[j[3:0]] && pat[j[3:0]] != n_window[k]) begin
                    pos_ok[k] = 1'b0;
                end
            end
        end
    end

    assign all_ok    = &pos_ok;
    assign seen_base = i_data.search_start ? 1'b0 : r_seen;
    assign match     = !seen_base && (i_eff_len != '0) && (n_fill >= i_eff_len) && all_ok;
    assign n_seen    = seen_base || match;

    assign o_push              = accept && (match || (i_data.last_byte && !seen_base));
    assign o_entry.found       = match;
    assign o_entry.end_address = i_data.byte_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_seen <= 1'b0;
        end else if (accept) begin
            r_fill <= n_fill;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window <= n_window;
        end
    end

endmodule

// ----- rtl/msscan_queue.sv -----
`timescale 1ns / 1ps
module msscan_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  msscan_pkg::t_qent   i_entry,
    input  logic                i_pop,
    output msscan_pkg::t_qent   o_head,
    output msscan_pkg::t_q_stat o_stat
);
    import msscan_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qent            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (int'(r_wr) == QUEUE_DEPTH - 1) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (int'(r_rd) == QUEUE_DEPTH - 1) ? '0 : r_rd + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (int'(r_cnt) == QUEUE_DEPTH);
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ----- rtl/msscan_back.sv -----
`timescale 1ns / 1ps
module msscan_back #(
    parameter int PATTERN_MAX = msscan_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msscan_pkg::t_q_stat i_q_stat,
    input  msscan_pkg::t_qent   i_head,
    output logic                o_pop,
    input  logic [LEN_W-1:0]    i_eff_len,
    output logic                o_valid,
    input  logic                i_stall,
    output msscan_pkg::t_out    o_data
);
    import msscan_pkg::*;

    logic r_valid, n_valid;
    t_out r_data, n_data;

    assign o_pop = !i_q_stat.empty && (!r_valid || !i_stall);

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_stall;
        end
        // Step back from the closing byte to the first byte of the match.
        n_data.found = i_head.found;
        if (i_head.found) begin
            n_data.match_address = i_head.end_address - 64'(LEN_W'(i_eff_len - LEN_W'(1)));
        end else begin
            n_data.match_address = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/masked_byte_signature_scan_unit.sv -----
`timescale 1ns / 1ps
// Wildcard byte pattern search over a stream of addressed memory bytes. The block takes one
// byte per clock: every window slot is compared against its pattern byte in parallel in the
// front stage. A match or not-found result is queued in a two-entry queue and then moves to
// the output register; the input side stalls only while that queue is full. A search gives at
// most one result: the start address of its first match, or a not-found result on its last
// byte. Pattern registers are written through the configuration port, which is always ready,
// and must only change while idle.
module masked_byte_signature_scan_unit #(
    parameter int PATTERN_MAX = msscan_pkg::PATTERN_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  msscan_pkg::t_in                     i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output msscan_pkg::t_out                    o_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msscan_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);
    import msscan_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    t_cfg             r_cfg, n_cfg;
    logic [LEN_W-1:0] eff_len;
    logic             push, pop;
    t_qent            entry, head;
    t_q_stat          q_stat;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:  n_cfg.pattern_bytes_low  = i_cfg_data;
                CFG_PATTERN_HIGH: n_cfg.pattern_bytes_high = i_cfg_data;
                CFG_CARE_MASK:    n_cfg.care_mask          = i_cfg_data[15:0];
                CFG_PATTERN_LEN:  n_cfg.pattern_length     = i_cfg_data[LEN_CFG_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Clamp the length to the window depth.
    always_comb begin
        if (int'(r_cfg.pattern_length) > PATTERN_MAX) begin
            eff_len = LEN_W'(PATTERN_MAX);
        end else begin
            eff_len = LEN_W'(r_cfg.pattern_length);
        end
    end

    msscan_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .o_stall   (o_stall),
        .i_cfg     (r_cfg),
        .i_eff_len (eff_len),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_entry   (entry)
    );

    msscan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    msscan_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (q_stat),
        .i_head    (head),
        .o_pop     (pop),
        .i_eff_len (eff_len),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("result queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("result queue read while empty");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.found || o_data.match_address == 64'd0))
        else $error("not-found result carries an address");

endmodule
